### src/m3acc_pkg.sv
`default_nettype none

package m3acc_pkg;

  localparam int unsigned ElemW     = 16;
  localparam int unsigned FracBitsDef = 8;
  localparam int unsigned DetW      = 40;
  localparam int unsigned OpW       = 3;
  localparam int unsigned MatDim    = 3;
  localparam int unsigned ColW      = 2;
  localparam int unsigned MulSumW   = 2 * ElemW + 2;

  typedef logic signed [ElemW-1:0] elem_t;
  typedef elem_t [MatDim-1:0] row_t;
  typedef row_t [MatDim-1:0] mat_t;

  typedef enum logic [OpW-1:0] {
    OP_LOAD = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_HOLD = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_COL,
    S_MINOR,
    S_PROD
  } state_e;

  typedef struct packed {
    logic [OpW-1:0] operation;
    elem_t in_r0c0;
    elem_t in_r0c1;
    elem_t in_r0c2;
    elem_t in_r1c0;
    elem_t in_r1c1;
    elem_t in_r1c2;
    elem_t in_r2c0;
    elem_t in_r2c1;
    elem_t in_r2c2;
  } in_item_t;

  typedef struct packed {
    elem_t out_r0c0;
    elem_t out_r0c1;
    elem_t out_r0c2;
    elem_t out_r1c0;
    elem_t out_r1c1;
    elem_t out_r1c2;
    elem_t out_r2c0;
    elem_t out_r2c1;
    elem_t out_r2c2;
    logic signed [DetW-1:0] determinant;
  } out_item_t;

  typedef struct packed {
    logic           step;
    logic [ColW-1:0] col;
    logic [OpW-1:0] op;
  } lane_ctrl_t;

  function automatic elem_t sat_elem(input logic signed [MulSumW-1:0] v);
    logic [MulSumW-ElemW:0] upper;
    logic                   fits;
    upper = v[MulSumW-1:ElemW-1];
    fits  = (&upper) | ~(|upper);
    if (fits) begin
      return v[ElemW-1:0];
    end else if (v[MulSumW-1]) begin
      return {1'b1, {(ElemW-1){1'b0}}};
    end else begin
      return {1'b0, {(ElemW-1){1'b1}}};
    end
  endfunction

endpackage

`default_nettype wire

### src/m3acc_lane.sv
`default_nettype none

module m3acc_lane #(
  parameter int unsigned FRAC_BITS = m3acc_pkg::FracBitsDef
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  m3acc_pkg::lane_ctrl_t  ctrl_i,
  input  m3acc_pkg::row_t        b_col_i,
  input  m3acc_pkg::elem_t       b_self_i,
  output m3acc_pkg::row_t        row_o
);

  localparam int unsigned SW = m3acc_pkg::MulSumW;
  localparam int unsigned PW = 2 * m3acc_pkg::ElemW;

  m3acc_pkg::row_t  row_q;
  m3acc_pkg::elem_t part_q [2];
  m3acc_pkg::elem_t a_cur;
  m3acc_pkg::elem_t elem_new;
  logic signed [PW-1:0] prod [m3acc_pkg::MatDim];
  logic signed [SW-1:0] mul_sum;
  logic signed [SW-1:0] mul_shift;
  logic signed [SW-1:0] add_sum;
  logic signed [SW-1:0] sub_sum;

  always_comb begin
    unique case (ctrl_i.col)
      2'd0:    a_cur = row_q[0];
      2'd1:    a_cur = row_q[1];
      default: a_cur = row_q[2];
    endcase
    for (int k = 0; k < m3acc_pkg::MatDim; k++) begin
      prod[k] = $signed(row_q[k]) * $signed(b_col_i[k]);
    end
    mul_sum   = SW'(prod[0]) + SW'(prod[1]) + SW'(prod[2]);
    mul_shift = mul_sum >>> FRAC_BITS;
    add_sum   = SW'($signed(a_cur)) + SW'($signed(b_self_i));
    sub_sum   = SW'($signed(a_cur)) - SW'($signed(b_self_i));
    unique case (ctrl_i.op)
      m3acc_pkg::OP_LOAD: elem_new = b_self_i;
      m3acc_pkg::OP_ADD:  elem_new = m3acc_pkg::sat_elem(add_sum);
      m3acc_pkg::OP_SUB:  elem_new = m3acc_pkg::sat_elem(sub_sum);
      m3acc_pkg::OP_MUL:  elem_new = m3acc_pkg::sat_elem(mul_shift);
      default:            elem_new = a_cur;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
    end else if (ctrl_i.step && ctrl_i.col == 2'd2) begin
      row_q <= {elem_new, part_q[1], part_q[0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.step && ctrl_i.col != 2'd2) begin
      part_q[ctrl_i.col[0]] <= elem_new;
    end
  end

  assign row_o = row_q;

endmodule

`default_nettype wire

### src/m3acc_det.sv
`default_nettype none

module m3acc_det #(
  parameter int unsigned FRAC_BITS = m3acc_pkg::FracBitsDef
) (
  input  wire                            clk_i,
  input  m3acc_pkg::row_t                r0_i,
  input  m3acc_pkg::row_t                r1_i,
  input  m3acc_pkg::row_t                r2_i,
  input  wire                            minor_en_i,
  output logic signed [m3acc_pkg::DetW-1:0] det_o
);

  localparam int unsigned EW    = m3acc_pkg::ElemW;
  localparam int unsigned PW    = 2 * EW;
  localparam int unsigned MinW  = 2 * EW + 1;
  localparam int unsigned QW    = EW + MinW;
  localparam int unsigned DSumW = QW + 2;
  localparam int unsigned ExtW  = DSumW + 2 * FRAC_BITS + m3acc_pkg::DetW;

  logic signed [PW-1:0]    pa [m3acc_pkg::MatDim];
  logic signed [PW-1:0]    pb [m3acc_pkg::MatDim];
  logic signed [MinW-1:0]  minor_d [m3acc_pkg::MatDim];
  logic signed [MinW-1:0]  minor_q [m3acc_pkg::MatDim];
  logic signed [QW-1:0]    q [m3acc_pkg::MatDim];
  logic signed [DSumW-1:0] dsum;
  logic signed [ExtW-1:0]  dext;
  logic signed [ExtW-1:0]  dshift;

  always_comb begin
    pa[0] = $signed(r1_i[1]) * $signed(r2_i[2]);
    pb[0] = $signed(r1_i[2]) * $signed(r2_i[1]);
    pa[1] = $signed(r1_i[2]) * $signed(r2_i[0]);
    pb[1] = $signed(r1_i[0]) * $signed(r2_i[2]);
    pa[2] = $signed(r1_i[0]) * $signed(r2_i[1]);
    pb[2] = $signed(r1_i[1]) * $signed(r2_i[0]);
    for (int k = 0; k < m3acc_pkg::MatDim; k++) begin
      minor_d[k] = MinW'(pa[k]) - MinW'(pb[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (minor_en_i) begin
      minor_q <= minor_d;
    end
  end

  always_comb begin
    for (int k = 0; k < m3acc_pkg::MatDim; k++) begin
      q[k] = $signed(r0_i[k]) * minor_q[k];
    end
    dsum   = DSumW'(q[0]) + DSumW'(q[1]) + DSumW'(q[2]);
    dext   = ExtW'(dsum);
    dshift = dext >>> (2 * FRAC_BITS);
    det_o  = dshift[m3acc_pkg::DetW-1:0];
  end

endmodule

`default_nettype wire

### src/matrix3x3_accumulator_alu_core.sv
// An accepted item passes through the column steps, the cofactor register and the output
// register before its result is valid. A new item is taken only while idle or as the previous
// result moves into the output register, so items do not overlap. Each row lane steps through
// its three columns, then the determinant unit registers the cofactors and forms the products.
// Reset clears the accumulator to zero and empties the output register.
`default_nettype none

module matrix3x3_accumulator_alu_core #(
  parameter int unsigned FRAC_BITS = m3acc_pkg::FracBitsDef
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_stall_o,
  input  m3acc_pkg::in_item_t   in_item_i,
  output logic                  out_valid_o,
  input  wire                   out_stall_i,
  output m3acc_pkg::out_item_t  out_item_o
);

  m3acc_pkg::state_e     state_q, state_d;
  logic [m3acc_pkg::ColW-1:0] col_q, col_d;
  logic [m3acc_pkg::OpW-1:0]  op_q;
  m3acc_pkg::mat_t       b_q;
  m3acc_pkg::row_t       b_col;
  m3acc_pkg::row_t       rows [m3acc_pkg::MatDim];
  m3acc_pkg::lane_ctrl_t lane_ctrl;
  logic                  minor_en;
  logic signed [m3acc_pkg::DetW-1:0] det;
  logic                  in_accept;
  logic                  out_load;
  logic                  out_valid_q, out_valid_d;
  m3acc_pkg::out_item_t  out_item_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      m3acc_pkg::S_IDLE: begin
        if (in_accept) state_d = m3acc_pkg::S_COL;
      end
      m3acc_pkg::S_COL: begin
        if (col_q == 2'd2) state_d = m3acc_pkg::S_MINOR;
      end
      m3acc_pkg::S_MINOR: state_d = m3acc_pkg::S_PROD;
      m3acc_pkg::S_PROD: begin
        if (out_load) state_d = in_accept ? m3acc_pkg::S_COL : m3acc_pkg::S_IDLE;
      end
      default: state_d = m3acc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    out_load   = (state_q == m3acc_pkg::S_PROD) && (!out_valid_q || !out_stall_i);
    in_stall_o = !((state_q == m3acc_pkg::S_IDLE) || out_load);
    in_accept  = in_valid_i && !in_stall_o;
    minor_en   = (state_q == m3acc_pkg::S_MINOR);
    lane_ctrl.step = (state_q == m3acc_pkg::S_COL);
    lane_ctrl.col  = col_q;
    lane_ctrl.op   = op_q;
    if (state_q == m3acc_pkg::S_COL && col_q != 2'd2) begin
      col_d = col_q + 2'd1;
    end else begin
      col_d = '0;
    end
    out_valid_d = out_load || (out_valid_q && out_stall_i);
  end

  always_comb begin
    for (int k = 0; k < m3acc_pkg::MatDim; k++) begin
      unique case (col_q)
        2'd0:    b_col[k] = b_q[k][0];
        2'd1:    b_col[k] = b_q[k][1];
        default: b_col[k] = b_q[k][2];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= m3acc_pkg::S_IDLE;
      col_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      col_q       <= col_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q       <= in_item_i.operation;
      b_q[0][0]  <= in_item_i.in_r0c0;
      b_q[0][1]  <= in_item_i.in_r0c1;
      b_q[0][2]  <= in_item_i.in_r0c2;
      b_q[1][0]  <= in_item_i.in_r1c0;
      b_q[1][1]  <= in_item_i.in_r1c1;
      b_q[1][2]  <= in_item_i.in_r1c2;
      b_q[2][0]  <= in_item_i.in_r2c0;
      b_q[2][1]  <= in_item_i.in_r2c1;
      b_q[2][2]  <= in_item_i.in_r2c2;
    end
    if (out_load) begin
      out_item_q.out_r0c0    <= rows[0][0];
      out_item_q.out_r0c1    <= rows[0][1];
      out_item_q.out_r0c2    <= rows[0][2];
      out_item_q.out_r1c0    <= rows[1][0];
      out_item_q.out_r1c1    <= rows[1][1];
      out_item_q.out_r1c2    <= rows[1][2];
      out_item_q.out_r2c0    <= rows[2][0];
      out_item_q.out_r2c1    <= rows[2][1];
      out_item_q.out_r2c2    <= rows[2][2];
      out_item_q.determinant <= det;
    end
  end

  for (genvar i = 0; i < m3acc_pkg::MatDim; i++) begin : g_lane
    m3acc_lane #(
      .FRAC_BITS(FRAC_BITS)
    ) u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (lane_ctrl),
      .b_col_i (b_col),
      .b_self_i(b_col[i]),
      .row_o   (rows[i])
    );
  end

  m3acc_det #(
    .FRAC_BITS(FRAC_BITS)
  ) u_det (
    .clk_i     (clk_i),
    .r0_i      (rows[0]),
    .r1_i      (rows[1]),
    .r2_i      (rows[2]),
    .minor_en_i(minor_en),
    .det_o     (det)
  );

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

### src/m3acc_chk.sv
`default_nettype none

module m3acc_chk (
  input wire                  clk_i,
  input wire                  rst_ni,
  input wire                  in_valid_i,
  input wire                  in_stall_o,
  input wire                  out_valid_o,
  input wire                  out_stall_i,
  input m3acc_pkg::out_item_t out_item_o
);

  logic in_acc;
  logic all_zero;

  assign in_acc = in_valid_i && !in_stall_o;
  assign all_zero = out_item_o.out_r0c0 == '0 && out_item_o.out_r0c1 == '0 &&
                    out_item_o.out_r0c2 == '0 && out_item_o.out_r1c0 == '0 &&
                    out_item_o.out_r1c1 == '0 && out_item_o.out_r1c2 == '0 &&
                    out_item_o.out_r2c0 == '0 && out_item_o.out_r2c1 == '0 &&
                    out_item_o.out_r2c2 == '0;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("Stalled result item changed or vanished.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o ##1 in_stall_o ##1 in_stall_o)
    else $error("Input taken again while an item is still being processed.");

  a_result_timing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_acc, 6))
    else $error("Result item appeared without an item accepted six edges before.");

  a_zero_det: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && all_zero |-> out_item_o.determinant == '0)
    else $error("Zero matrix reported a nonzero determinant.");

endmodule

bind matrix3x3_accumulator_alu_core m3acc_chk u_m3acc_chk (.*);

`default_nettype wire

### verif/matrix3x3_accumulator_alu_core_tb.sv
`timescale 1ns / 1ps

module matrix3x3_accumulator_alu_core_tb;
  import m3acc_pkg::*;

  localparam logic [OpW-1:0] OP_SPARE5 = 3'd5;
  localparam logic [OpW-1:0] OP_SPARE6 = 3'd6;
  localparam logic [OpW-1:0] OP_SPARE7 = 3'd7;
  localparam longint ElemMax = (longint'(1) <<< (ElemW - 1)) - 1;
  localparam longint ElemMin = -ElemMax - 1;
  localparam elem_t EMAX = 16'sh7fff;
  localparam elem_t EMIN = 16'sh8000;
  localparam elem_t ONE_Q88 = 16'sh0100;
  localparam int unsigned RandomPhaseItems = 420;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  in_item_t in_item = '0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  out_item_t out_item;

  elem_t acc_q [9];
  out_item_t expected_acc_q [$];
  int unsigned mismatch_cnt = 0;
  int unsigned src_max_wait = 11;
  int unsigned sink_max_wait = 11;
  int unsigned sink_hold_cycles = 0;

  matrix3x3_accumulator_alu_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  always #6 clk_i = ~clk_i;

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic elem_t clamp_elem(input longint v);
    if (v > ElemMax) begin
      return EMAX;
    end else if (v < ElemMin) begin
      return EMIN;
    end
    return elem_t'(v);
  endfunction

  function automatic out_item_t step_accumulator(input in_item_t it);
    elem_t b [9];
    elem_t nxt [9];
    longint s;
    longint pos;
    longint neg;
    longint det;
    out_item_t r;
    b[0] = it.in_r0c0; b[1] = it.in_r0c1; b[2] = it.in_r0c2;
    b[3] = it.in_r1c0; b[4] = it.in_r1c1; b[5] = it.in_r1c2;
    b[6] = it.in_r2c0; b[7] = it.in_r2c1; b[8] = it.in_r2c2;
    for (int i = 0; i < 9; i++) nxt[i] = acc_q[i];
    case (it.operation)
      OP_LOAD: begin
        for (int i = 0; i < 9; i++) nxt[i] = b[i];
      end
      OP_ADD: begin
        for (int i = 0; i < 9; i++) nxt[i] = clamp_elem(longint'(acc_q[i]) + longint'(b[i]));
      end
      OP_SUB: begin
        for (int i = 0; i < 9; i++) nxt[i] = clamp_elem(longint'(acc_q[i]) - longint'(b[i]));
      end
      OP_MUL: begin
        for (int i = 0; i < 3; i++) begin
          for (int j = 0; j < 3; j++) begin
            s = 0;
            for (int k = 0; k < 3; k++) begin
              s += longint'(acc_q[i*3+k]) * longint'(b[k*3+j]);
            end
            nxt[i*3+j] = clamp_elem(s >>> FracBitsDef);
          end
        end
      end
      default: begin
      end
    endcase
    for (int i = 0; i < 9; i++) acc_q[i] = nxt[i];
    pos = longint'(nxt[0]) * nxt[4] * nxt[8] + longint'(nxt[1]) * nxt[5] * nxt[6]
        + longint'(nxt[2]) * nxt[3] * nxt[7];
    neg = longint'(nxt[6]) * nxt[4] * nxt[2] + longint'(nxt[7]) * nxt[5] * nxt[0]
        + longint'(nxt[8]) * nxt[3] * nxt[1];
    det = (pos - neg) >>> (2 * FracBitsDef);
    r.out_r0c0 = nxt[0]; r.out_r0c1 = nxt[1]; r.out_r0c2 = nxt[2];
    r.out_r1c0 = nxt[3]; r.out_r1c1 = nxt[4]; r.out_r1c2 = nxt[5];
    r.out_r2c0 = nxt[6]; r.out_r2c1 = nxt[7]; r.out_r2c2 = nxt[8];
    r.determinant = det[DetW-1:0];
    return r;
  endfunction

  function automatic in_item_t diag_item(input logic [OpW-1:0] op, input elem_t diag,
                                         input elem_t off);
    in_item_t it;
    it.operation = op;
    it.in_r0c0 = diag; it.in_r0c1 = off;  it.in_r0c2 = off;
    it.in_r1c0 = off;  it.in_r1c1 = diag; it.in_r1c2 = off;
    it.in_r2c0 = off;  it.in_r2c1 = off;  it.in_r2c2 = diag;
    return it;
  endfunction

  function automatic elem_t rand_q88();
    case ($urandom_range(0, 3))
      0: return elem_t'($urandom);
      1: return elem_t'(int'($urandom_range(0, 1023)) - 512);
      2: begin
        case ($urandom_range(0, 5))
          0: return EMAX;
          1: return EMIN;
          2: return '0;
          3: return -16'sd1;
          4: return ONE_Q88;
          default: return -ONE_Q88;
        endcase
      end
      default: return elem_t'(int'(ONE_Q88) + int'($urandom_range(0, 64)) - 32);
    endcase
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      it.operation = OP_LOAD;
    end else if (pick < 35) begin
      it.operation = OP_ADD;
    end else if (pick < 50) begin
      it.operation = OP_SUB;
    end else if (pick < 80) begin
      it.operation = OP_MUL;
    end else if (pick < 90) begin
      it.operation = OP_HOLD;
    end else begin
      it.operation = OP_SPARE5 + 3'($urandom_range(0, 2));
    end
    it.in_r0c0 = rand_q88(); it.in_r0c1 = rand_q88(); it.in_r0c2 = rand_q88();
    it.in_r1c0 = rand_q88(); it.in_r1c1 = rand_q88(); it.in_r1c2 = rand_q88();
    it.in_r2c0 = rand_q88(); it.in_r2c1 = rand_q88(); it.in_r2c2 = rand_q88();
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    int unsigned gap;
    gap = $urandom_range(0, src_max_wait);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk_i); while (in_stall);
    expected_acc_q.push_back(step_accumulator(it));
  endtask

  function automatic void check_elem(input string tag, input elem_t want, input elem_t got);
    if (want !== got) begin
      $display("%0t: element %s expected %0d actual %0d", $time, tag, want, got);
      mismatch_cnt++;
    end
  endfunction

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_acc_q.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %h", $time, out_item);
        mismatch_cnt++;
      end else begin
        want = expected_acc_q.pop_front();
        check_elem("r0c0", want.out_r0c0, out_item.out_r0c0);
        check_elem("r0c1", want.out_r0c1, out_item.out_r0c1);
        check_elem("r0c2", want.out_r0c2, out_item.out_r0c2);
        check_elem("r1c0", want.out_r1c0, out_item.out_r1c0);
        check_elem("r1c1", want.out_r1c1, out_item.out_r1c1);
        check_elem("r1c2", want.out_r1c2, out_item.out_r1c2);
        check_elem("r2c0", want.out_r2c0, out_item.out_r2c0);
        check_elem("r2c1", want.out_r2c1, out_item.out_r2c1);
        check_elem("r2c2", want.out_r2c2, out_item.out_r2c2);
        if (want.determinant !== out_item.determinant) begin
          $display("%0t: determinant expected %0d actual %0d", $time, want.determinant,
                   out_item.determinant);
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin
    int unsigned n;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (sink_hold_cycles != 0) begin
        n = sink_hold_cycles;
        sink_hold_cycles = 0;
      end else begin
        n = $urandom_range(0, sink_max_wait);
      end
      if (n != 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall <= 1'b0;
      do @(posedge clk_i); while (!out_valid);
    end
  end

  task automatic test_reset_and_hold();
    send_item(diag_item(OP_HOLD, EMAX, EMIN));
    send_item(diag_item(OP_LOAD, ONE_Q88, 16'sd3));
    send_item(diag_item(OP_SPARE5, EMIN, EMAX));
    send_item(diag_item(OP_SPARE6, EMAX, EMAX));
    send_item(diag_item(OP_SPARE7, EMIN, EMIN));
  endtask

  task automatic test_load_extremes();
    send_item(diag_item(OP_LOAD, EMAX, EMAX));
    send_item(diag_item(OP_LOAD, EMIN, EMIN));
    send_item(diag_item(OP_LOAD, EMAX, EMIN));
    send_item(diag_item(OP_LOAD, EMIN, EMAX));
    send_item(diag_item(OP_LOAD, 16'sh5555, 16'shaaaa));
  endtask

  task automatic test_saturating_add_sub();
    send_item(diag_item(OP_LOAD, EMAX, EMAX));
    send_item(diag_item(OP_ADD, EMAX, 16'sd1));
    send_item(diag_item(OP_LOAD, EMIN, EMIN));
    send_item(diag_item(OP_ADD, EMIN, -16'sd1));
    send_item(diag_item(OP_LOAD, EMIN, '0));
    send_item(diag_item(OP_SUB, EMAX, EMAX));
    send_item(diag_item(OP_LOAD, EMAX, '0));
    send_item(diag_item(OP_SUB, EMIN, EMIN));
  endtask

  task automatic test_multiply();
    send_item(diag_item(OP_LOAD, ONE_Q88, '0));
    send_item(diag_item(OP_MUL, 16'sd300, -16'sd77));
    send_item(diag_item(OP_LOAD, EMAX, EMAX));
    send_item(diag_item(OP_MUL, EMAX, EMAX));
    // A tiny negative product must round toward minus infinity, not toward zero.
    send_item(diag_item(OP_LOAD, -16'sd1, -16'sd1));
    send_item(diag_item(OP_MUL, 16'sd1, '0));
    send_item(diag_item(OP_LOAD, EMAX, EMIN));
    send_item(diag_item(OP_MUL, EMIN, EMAX));
  endtask

  task automatic test_output_backpressure();
    src_max_wait = 0;
    sink_hold_cycles = 300;
    repeat (24) send_item(rand_item());
    src_max_wait = 11;
  endtask

  task automatic test_random_traffic();
    int unsigned src_cfg [4] = '{11, 0, 0, 11};
    int unsigned sink_cfg [4] = '{11, 0, 11, 0};
    for (int p = 0; p < 4; p++) begin
      src_max_wait = src_cfg[p];
      sink_max_wait = sink_cfg[p];
      repeat (RandomPhaseItems) send_item(rand_item());
    end
    src_max_wait = 11;
    sink_max_wait = 11;
  endtask

  initial begin
    for (int i = 0; i < 9; i++) acc_q[i] = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_and_hold();
    test_load_extremes();
    test_saturating_add_sub();
    test_multiply();
    test_output_backpressure();
    test_random_traffic();
    in_valid <= 1'b0;
    while (expected_acc_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
